FILE: hdl/ransac_plane_inlier_engine_defines.svh
// Assertion macros used by the plane inlier engine datapath.
`ifndef RANSAC_PLANE_INLIER_ENGINE_DEFINES_SVH
`define RANSAC_PLANE_INLIER_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define RPIE_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define RPIE_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
`else
`define RPIE_ASSERT_ALWAYS(lbl, expr, msg)
`define RPIE_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/rpie_pkg.sv
// Shared types and constants of the plane inlier engine.
package rpie_pkg;
   localparam int MAX_POINTS_DEF = 1024;
   localparam int COORD_BITS_DEF = 16;
   localparam int IDX_BITS = 10;
   localparam int CNT_OUT_BITS = 11;
   localparam int TOL_BITS = 16;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd51;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_TRIAL = 2'd1;
   localparam logic [1:0] OP_CLASSIFY = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;

   localparam logic [1:0] RD_I1 = 2'd0;
   localparam logic [1:0] RD_I2 = 2'd1;
   localparam logic [1:0] RD_I3 = 2'd2;
   localparam logic [1:0] RD_K = 2'd3;

   // Multiply steps in the order the controller issues them.
   localparam logic [3:0] M_UYVZ = 4'd0;
   localparam logic [3:0] M_UZVY = 4'd1;
   localparam logic [3:0] M_UZVX = 4'd2;
   localparam logic [3:0] M_UXVZ = 4'd3;
   localparam logic [3:0] M_UXVY = 4'd4;
   localparam logic [3:0] M_UYVX = 4'd5;
   localparam logic [3:0] M_AA = 4'd6;
   localparam logic [3:0] M_BB = 4'd7;
   localparam logic [3:0] M_CC = 4'd8;
   localparam logic [3:0] M_TT = 4'd9;
   localparam logic [3:0] M_LIM = 4'd10;
   localparam logic [3:0] M_ADX = 4'd11;
   localparam logic [3:0] M_BDY = 4'd12;
   localparam logic [3:0] M_CDZ = 4'd13;
   localparam logic [3:0] M_RR = 4'd14;

   typedef struct packed {
      logic       cap_item;
      logic       k_init;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       cap_base;
      logic       cap_u;
      logic       cap_v;
      logic       cap_pt;
      logic       mult_start;
      logic [3:0] mult_op;
      logic       mult_store;
      logic       k_inc;
      logic       fin;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       err;
      logic       last_point;
      logic       mult_done;
      logic       out_free;
   } stat_type;
endpackage

FILE: hdl/rpie_if.sv
// Request and response channel interfaces of the plane inlier engine.
interface rpie_req_if #(parameter int COORD_BITS = rpie_pkg::COORD_BITS_DEF);
   logic                                valid;
   logic                                ready;
   logic [1:0]                          opcode;
   logic signed [COORD_BITS-1:0]        coord_x;
   logic signed [COORD_BITS-1:0]        coord_y;
   logic signed [COORD_BITS-1:0]        coord_z;
   logic [rpie_pkg::IDX_BITS-1:0]       first_index;
   logic [rpie_pkg::IDX_BITS-1:0]       second_index;
   logic [rpie_pkg::IDX_BITS-1:0]       third_index;
   modport source (output valid, opcode, coord_x, coord_y, coord_z, first_index,
                   second_index, third_index, input ready);
   modport sink (input valid, opcode, coord_x, coord_y, coord_z, first_index,
                 second_index, third_index, output ready);
endinterface

interface rpie_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic [rpie_pkg::CNT_OUT_BITS-1:0]   inlier_count;
   logic                                new_best;
   logic [rpie_pkg::CNT_OUT_BITS-1:0]   best_count;
   logic                                is_inlier;
   modport source (output valid, status, inlier_count, new_best, best_count, is_inlier,
                   input ready);
   modport sink (input valid, status, inlier_count, new_best, best_count, is_inlier,
                 output ready);
endinterface

FILE: hdl/rpie_ram.sv
// Generic single write port, single read port RAM with registered read.
module rpie_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/rpie_mult.sv
// Shared sign-magnitude multiplier that retires eight multiplier bits a cycle.
module rpie_mult #(
   parameter int MA = 68,
   parameter int MB = 51,
   parameter int PW = 102
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MA-1:0]        a_mag,
   input  logic [MB-1:0]        b_mag,
   input  logic                 neg,
   output logic                 done,
   output logic signed [PW:0]   product
);
   logic          busy_ff, busy_in;
   logic          neg_ff, neg_in;
   logic [PW-1:0] a_ff, a_in;
   logic [MB-1:0] b_ff, b_in;
   logic [PW-1:0] acc_ff, acc_in;
   logic [PW-1:0] part;

   assign part = a_ff * {{(PW-8){1'b0}}, b_ff[7:0]};
   assign done = busy_ff && (b_ff == '0);

   always_comb begin
      busy_in = busy_ff;
      neg_in = neg_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in = neg;
         a_in = {{(PW-MA){1'b0}}, a_mag};
         b_in = b_mag;
         acc_in = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         acc_in = acc_ff + part;
         a_in = a_ff << 8;
         b_in = b_ff >> 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff <= neg_in;
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

   assign product = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
endmodule

FILE: hdl/rpie_ctrl.sv
// Controller state machine that sequences loads, plane set-up and the point walk.
module rpie_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rpie_pkg::stat_type stat,
   output rpie_pkg::cmd_type  cmd
);
   import rpie_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DEC = 4'd1;
   localparam logic [3:0] S_RD1 = 4'd2;
   localparam logic [3:0] S_RD2 = 4'd3;
   localparam logic [3:0] S_RD3 = 4'd4;
   localparam logic [3:0] S_RDV = 4'd5;
   localparam logic [3:0] S_MGO = 4'd6;
   localparam logic [3:0] S_MWAIT = 4'd7;
   localparam logic [3:0] S_PRD = 4'd8;
   localparam logic [3:0] S_PCAP = 4'd9;
   localparam logic [3:0] S_PNEXT = 4'd10;
   localparam logic [3:0] S_FIN = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [3:0] op_ff, op_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      cmd = '0;
      cmd.mult_op = op_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.cap_item = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (!stat.err && (stat.op == OP_TRIAL || stat.op == OP_CLASSIFY)) begin
               state_in = S_RD1;
            end else begin
               state_in = S_FIN;
            end
         end
         S_RD1: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_I1;
            cmd.k_init = 1'b1;
            state_in = S_RD2;
         end
         S_RD2: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_I2;
            cmd.cap_base = 1'b1;
            state_in = S_RD3;
         end
         S_RD3: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_I3;
            cmd.cap_u = 1'b1;
            state_in = S_RDV;
         end
         S_RDV: begin
            cmd.cap_v = 1'b1;
            op_in = M_UYVZ;
            state_in = S_MGO;
         end
         S_MGO: begin
            cmd.mult_start = 1'b1;
            state_in = S_MWAIT;
         end
         S_MWAIT: begin
            if (stat.mult_done) begin
               cmd.mult_store = 1'b1;
               if (op_ff == M_LIM) begin
                  state_in = S_PRD;
               end else if (op_ff == M_RR) begin
                  state_in = S_PNEXT;
               end else begin
                  op_in = op_ff + 4'd1;
                  state_in = S_MGO;
               end
            end
         end
         S_PRD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = RD_K;
            state_in = S_PCAP;
         end
         S_PCAP: begin
            cmd.cap_pt = 1'b1;
            op_in = M_ADX;
            state_in = S_MGO;
         end
         S_PNEXT: begin
            if (stat.last_point) begin
               state_in = S_FIN;
            end else begin
               cmd.k_inc = 1'b1;
               state_in = S_PRD;
            end
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.fin = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff <= M_UYVZ;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
      end
   end
endmodule

FILE: hdl/rpie_datapath.sv
// Datapath: point store, plane registers, shared multiplier, best plane and response word.
`include "ransac_plane_inlier_engine_defines.svh"

module rpie_datapath #(
   parameter int MAX_POINTS = rpie_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = rpie_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rpie_pkg::cmd_type                   cmd,
   output rpie_pkg::stat_type                  stat,
   input  logic                                csr_wr_en,
   input  logic [rpie_pkg::TOL_BITS-1:0]       csr_wr_data,
   input  logic [1:0]                          req_opcode,
   input  logic signed [COORD_BITS-1:0]        req_coord_x,
   input  logic signed [COORD_BITS-1:0]        req_coord_y,
   input  logic signed [COORD_BITS-1:0]        req_coord_z,
   input  logic [rpie_pkg::IDX_BITS-1:0]       req_first_index,
   input  logic [rpie_pkg::IDX_BITS-1:0]       req_second_index,
   input  logic [rpie_pkg::IDX_BITS-1:0]       req_third_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [rpie_pkg::CNT_OUT_BITS-1:0]   rsp_inlier_count,
   output logic                                rsp_new_best,
   output logic [rpie_pkg::CNT_OUT_BITS-1:0]   rsp_best_count,
   output logic                                rsp_is_inlier
);
   import rpie_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int DB = CB + 1;
   localparam int AB = 2 * CB + 3;
   localparam int RB = 3 * CB + 4;
   localparam int MA = 4 * CB + 4;
   localparam int MB = (3 * CB + 3 > 32) ? 3 * CB + 3 : 32;
   localparam int PW = (6 * CB + 6 > 4 * CB + 36) ? 6 * CB + 6 : 4 * CB + 36;

   // Held request word.
   logic [1:0]           op_ff;
   logic [CB-1:0]        cx_ff, cy_ff, cz_ff;
   logic [IDX_BITS-1:0]  i1_ff, i2_ff, i3_ff;

   logic [CNTW-1:0]      loaded_ff, loaded_in;
   logic [IDX_BITS-1:0]  best1_ff, best1_in, best2_ff, best2_in, best3_ff, best3_in;
   logic [CNTW-1:0]      best_cnt_ff, best_cnt_in;
   logic [TOL_BITS-1:0]  tol_ff;

   logic signed [CB-1:0] bx_ff, by_ff, bz_ff;
   logic signed [DB-1:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff, dx_ff, dy_ff, dz_ff;
   logic signed [AB-1:0] t_ff, pa_ff, pb_ff, pc_ff;
   logic [MA-1:0]        norm_ff;
   logic [31:0]          tol2_ff;
   logic [PW-1:0]        limit_ff;
   logic [RB-1:0]        r_ff;
   logic                 hit_ff;
   logic [CNTW-1:0]      cnt_ff;
   logic [AW-1:0]        k_ff;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [CNT_OUT_BITS-1:0] rsp_inlier_count_ff, rsp_best_count_ff;
   logic                 rsp_new_best_ff, rsp_is_inlier_ff;

   logic [1:0]           st_code;
   logic                 err;
   logic [IDX_BITS-1:0]  pi1, pi2, pi3;
   logic [AW-1:0]        rd_addr;
   logic [3*CB-1:0]      rd_data;
   logic signed [CB-1:0] px, py, pz;
   logic signed [DB-1:0] qx, qy, qz;
   logic                 ram_we;
   logic                 is_trial, is_classify, fresh;
   logic signed [MA:0]   a_s;
   logic signed [MB:0]   b_s;
   logic [MA-1:0]        a_mag;
   logic [MB-1:0]        b_mag;
   logic                 m_done;
   logic signed [PW:0]   prod;

   assign is_trial = (op_ff == OP_TRIAL);
   assign is_classify = (op_ff == OP_CLASSIFY);

   always_comb begin
      st_code = ST_OK;
      case (op_ff)
         OP_LOAD: begin
            if (32'(loaded_ff) >= MAX_POINTS) st_code = ST_FULL;
         end
         OP_TRIAL: begin
            if (32'(i1_ff) >= 32'(loaded_ff) || 32'(i2_ff) >= 32'(loaded_ff) ||
                32'(i3_ff) >= 32'(loaded_ff) || i1_ff == i2_ff || i1_ff == i3_ff ||
                i2_ff == i3_ff) st_code = ST_BAD;
         end
         OP_CLASSIFY: begin
            if (32'(i1_ff) >= 32'(loaded_ff) || 32'(best1_ff) >= 32'(loaded_ff) ||
                32'(best2_ff) >= 32'(loaded_ff) || 32'(best3_ff) >= 32'(loaded_ff))
               st_code = ST_BAD;
         end
         default: begin
            st_code = ST_OK;
         end
      endcase
   end
   assign err = (st_code != ST_OK);

   // A classify builds the best plane; a trial builds its own.
   assign pi1 = is_classify ? best1_ff : i1_ff;
   assign pi2 = is_classify ? best2_ff : i2_ff;
   assign pi3 = is_classify ? best3_ff : i3_ff;

   always_comb begin
      case (cmd.rd_sel)
         RD_I1: rd_addr = AW'(pi1);
         RD_I2: rd_addr = AW'(pi2);
         RD_I3: rd_addr = AW'(pi3);
         default: rd_addr = k_ff;
      endcase
   end

   assign ram_we = cmd.fin && (op_ff == OP_LOAD) && !err;

   rpie_ram #(.WIDTH(3 * CB), .DEPTH(MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(loaded_ff)),
      .wr_data ({cx_ff, cy_ff, cz_ff}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign px = rd_data[3*CB-1:2*CB];
   assign py = rd_data[2*CB-1:CB];
   assign pz = rd_data[CB-1:0];
   assign qx = {px[CB-1], px} - {bx_ff[CB-1], bx_ff};
   assign qy = {py[CB-1], py} - {by_ff[CB-1], by_ff};
   assign qz = {pz[CB-1], pz} - {bz_ff[CB-1], bz_ff};

   always_comb begin
      a_s = '0;
      b_s = '0;
      case (cmd.mult_op)
         M_UYVZ: begin a_s = uy_ff; b_s = vz_ff; end
         M_UZVY: begin a_s = uz_ff; b_s = vy_ff; end
         M_UZVX: begin a_s = uz_ff; b_s = vx_ff; end
         M_UXVZ: begin a_s = ux_ff; b_s = vz_ff; end
         M_UXVY: begin a_s = ux_ff; b_s = vy_ff; end
         M_UYVX: begin a_s = uy_ff; b_s = vx_ff; end
         M_AA: begin a_s = pa_ff; b_s = pa_ff; end
         M_BB: begin a_s = pb_ff; b_s = pb_ff; end
         M_CC: begin a_s = pc_ff; b_s = pc_ff; end
         M_TT: begin a_s = $signed({1'b0, tol_ff}); b_s = $signed({1'b0, tol_ff}); end
         M_LIM: begin a_s = $signed({1'b0, norm_ff}); b_s = $signed({1'b0, tol2_ff}); end
         M_ADX: begin a_s = pa_ff; b_s = dx_ff; end
         M_BDY: begin a_s = pb_ff; b_s = dy_ff; end
         M_CDZ: begin a_s = pc_ff; b_s = dz_ff; end
         M_RR: begin a_s = $signed(r_ff); b_s = $signed(r_ff); end
         default: begin a_s = '0; b_s = '0; end
      endcase
   end

   assign a_mag = a_s[MA] ? MA'(-a_s) : a_s[MA-1:0];
   assign b_mag = b_s[MB] ? MB'(-b_s) : b_s[MB-1:0];

   rpie_mult #(.MA(MA), .MB(MB), .PW(PW)) u_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mult_start),
      .a_mag   (a_mag),
      .b_mag   (b_mag),
      .neg     (a_s[MA] ^ b_s[MB]),
      .done    (m_done),
      .product (prod)
   );

   always_ff @(posedge clock) begin
      if (cmd.cap_item) begin
         op_ff <= req_opcode;
         cx_ff <= req_coord_x;
         cy_ff <= req_coord_y;
         cz_ff <= req_coord_z;
         i1_ff <= req_first_index;
         i2_ff <= req_second_index;
         i3_ff <= req_third_index;
      end
      if (cmd.cap_base) begin
         bx_ff <= px;
         by_ff <= py;
         bz_ff <= pz;
      end
      if (cmd.cap_u) begin
         ux_ff <= qx;
         uy_ff <= qy;
         uz_ff <= qz;
      end
      if (cmd.cap_v) begin
         vx_ff <= qx;
         vy_ff <= qy;
         vz_ff <= qz;
      end
      if (cmd.cap_pt) begin
         dx_ff <= qx;
         dy_ff <= qy;
         dz_ff <= qz;
      end
      if (cmd.k_init) begin
         k_ff <= is_classify ? AW'(i1_ff) : '0;
         cnt_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.mult_store) begin
         case (cmd.mult_op)
            M_UYVZ, M_UZVX, M_UXVY: t_ff <= prod[AB-1:0];
            M_UZVY: pa_ff <= t_ff - prod[AB-1:0];
            M_UXVZ: pb_ff <= t_ff - prod[AB-1:0];
            M_UYVX: pc_ff <= t_ff - prod[AB-1:0];
            M_AA: norm_ff <= prod[MA-1:0];
            M_BB, M_CC: norm_ff <= norm_ff + prod[MA-1:0];
            M_TT: tol2_ff <= prod[31:0];
            M_LIM: limit_ff <= prod[PW-1:0];
            M_ADX: r_ff <= prod[RB-1:0];
            M_BDY, M_CDZ: r_ff <= r_ff + prod[RB-1:0];
            M_RR: begin
               hit_ff <= (prod[PW-1:0] < limit_ff);
               cnt_ff <= cnt_ff + CNTW'(prod[PW-1:0] < limit_ff);
            end
            default: begin
               hit_ff <= hit_ff;
            end
         endcase
      end
   end

   assign fresh = is_trial && !err && (cnt_ff > best_cnt_ff);

   always_comb begin
      loaded_in = loaded_ff;
      best1_in = best1_ff;
      best2_in = best2_ff;
      best3_in = best3_ff;
      best_cnt_in = best_cnt_ff;
      if (ram_we) begin
         loaded_in = loaded_ff + 1'b1;
      end
      if (op_ff == OP_CLEAR) begin
         loaded_in = '0;
         best1_in = IDX_BITS'(0);
         best2_in = IDX_BITS'(1);
         best3_in = IDX_BITS'(2);
         best_cnt_in = '0;
      end else if (fresh) begin
         best1_in = i1_ff;
         best2_in = i2_ff;
         best3_in = i3_ff;
         best_cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         best1_ff <= IDX_BITS'(0);
         best2_ff <= IDX_BITS'(1);
         best3_ff <= IDX_BITS'(2);
         best_cnt_ff <= '0;
         tol_ff <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
         if (cmd.fin) begin
            loaded_ff <= loaded_in;
            best1_ff <= best1_in;
            best2_ff <= best2_in;
            best3_ff <= best3_in;
            best_cnt_ff <= best_cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         rsp_status_ff <= st_code;
         rsp_inlier_count_ff <= (is_trial && !err) ? CNT_OUT_BITS'(cnt_ff) : '0;
         rsp_new_best_ff <= fresh;
         rsp_best_count_ff <= CNT_OUT_BITS'(best_cnt_in);
         rsp_is_inlier_ff <= is_classify && !err && hit_ff;
      end
   end

   assign stat.op = op_ff;
   assign stat.err = err;
   assign stat.last_point = is_classify || (32'(k_ff) + 1 == 32'(loaded_ff));
   assign stat.mult_done = m_done;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_inlier_count = rsp_inlier_count_ff;
   assign rsp_new_best = rsp_new_best_ff;
   assign rsp_best_count = rsp_best_count_ff;
   assign rsp_is_inlier = rsp_is_inlier_ff;

   `RPIE_ASSERT_ALWAYS(a_loaded_max, 32'(loaded_ff) <= MAX_POINTS, "point count over depth")
   `RPIE_ASSERT_ALWAYS(a_best_le_loaded, best_cnt_ff <= loaded_ff, "best count over points")
   `RPIE_ASSERT_IMPLY(a_new_best_word, rsp_valid_ff && rsp_new_best_ff,
      rsp_inlier_count_ff == rsp_best_count_ff && rsp_status_ff == ST_OK,
      "new best word inconsistent")
endmodule

FILE: hdl/ransac_plane_inlier_engine.sv
// Top level of the plane inlier engine: controller, datapath and channel wiring.
//
// The req_ch channel takes one word per operation: load a point, run a trial
// plane from three stored point indices, classify one stored point against the
// best plane, or clear the cloud. Every accepted word returns exactly one word
// on rsp_ch with status, the trial's inlier count, the new-best flag, the best
// count and the classify answer. The tolerance is written on csr_wr_en/csr_wr_data.
// One word is worked on at a time. A trial first builds the plane, then walks
// every stored point; a classify does one point. The work is paced by the
// single shared multiplier, which retires eight bits of its second operand
// per cycle, and by the one read port of the point store. If the receiver
// stalls, the finished word waits in the output register and the next word is
// still taken; it holds in its final state until the register frees. Reset
// (synchronous) empties the cloud, sets the best plane to points 0, 1, 2 with
// count zero and the tolerance to 51; the point store needs no clearing pass.
module ransac_plane_inlier_engine #(
   parameter int MAX_POINTS = rpie_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = rpie_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   rpie_req_if.sink                       req_ch,
   rpie_rsp_if.source                     rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [rpie_pkg::TOL_BITS-1:0]  csr_wr_data
);
   import rpie_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rpie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rpie_datapath #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_opcode       (req_ch.opcode),
      .req_coord_x      (req_ch.coord_x),
      .req_coord_y      (req_ch.coord_y),
      .req_coord_z      (req_ch.coord_z),
      .req_first_index  (req_ch.first_index),
      .req_second_index (req_ch.second_index),
      .req_third_index  (req_ch.third_index),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_status       (rsp_ch.status),
      .rsp_inlier_count (rsp_ch.inlier_count),
      .rsp_new_best     (rsp_ch.new_best),
      .rsp_best_count   (rsp_ch.best_count),
      .rsp_is_inlier    (rsp_ch.is_inlier)
   );
endmodule
